/* src/ppstd_pkg.sv */
// Shared types and constants for the PPS time discipline block.
package ppstd_pkg;

    // Command codes
    typedef enum logic [2:0] {
        CMD_EDGE   = 3'd0,
        CMD_GPS    = 3'd1,
        CMD_STAMP  = 3'd2,
        CMD_HEALTH = 3'd3,
        CMD_TAKE   = 3'd4
    } cmd_t;

    // Timeout register value out of reset, in microseconds
    localparam logic [31:0] TIMEOUT_RESET = 32'd2000000;

    // Long division of a 64-bit value by one million: a 28-bit leading chunk,
    // then three 12-bit chunks, each divided through a 31-bit reciprocal.
    localparam int DIV_STEPS = 4;
    localparam int CHUNK_W   = 12;
    localparam int FIRST_W   = 28;
    localparam int REST_W    = 64 - FIRST_W;
    localparam int QUO_W     = DIV_STEPS * CHUNK_W;

    localparam logic [19:0] US_PER_S  = 20'd1000000;
    // floor(n / 1e6) == (n * SEC_MAGIC) >> 50, exact for any 32-bit n
    localparam logic [30:0] SEC_MAGIC = 31'd1125899907;
    localparam int          SEC_SHIFT = 50;

    localparam logic [9:0]  US_PER_MS = 10'd1000;
    // floor(r / 1000) == (r * MS_MAGIC) >> 30, exact for any 20-bit r
    localparam logic [20:0] MS_MAGIC  = 21'd1073742;
    localparam int          MS_SHIFT  = 30;

    // Largest whole-second count whose millisecond age may still fit 32 bits
    localparam logic [QUO_W-1:0] AGE_SEC_MAX = QUO_W'(4294967);

    // Per-item control carried down the pipe
    typedef struct packed {
        logic        is_stamp;
        logic        is_health;
        logic        has_edge;
        logic        ge;
        logic        ok;
        logic        ep_load;
        logic        ep_add;
        logic [31:0] gepoch;
        logic        valid;
        logic        fix;
        logic        pending;
        logic [31:0] count;
    } ctl_t;

    // Division pipe payload
    typedef struct packed {
        logic [31:0]       n;
        logic [REST_W-1:0] rest;
        logic [QUO_W-1:0]  quo;
        logic [12:0]       qm;
        logic [19:0]       rem;
    } div_t;

endpackage

/* src/pps_time_discipline.sv */
// PPS time discipline: edge tracking, event stamping and timeout health check.
// Each item moves from the input register through the divide and scale stages into the output register.
// Throughput: one item per cycle; each stage has its own valid bit, so the input
// keeps accepting while a result waits, until all 11 stages hold an item.
// Depth is set by the 64-bit divide by one million: four chunk steps, two stages each.
// Reset (rst_n low, async) empties the pipe, clears all state, timeout = 2000000 us.
module pps_time_discipline (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  logic [2:0]  cmd,
    input  logic [63:0] time_us,
    input  logic [31:0] gps_epoch_s,
    input  logic        gps_fix,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [31:0] stamp_sec,
    output logic [19:0] stamp_frac_us,
    output logic        result_ok,
    output logic        valid_now,
    output logic        fix_now,
    output logic [31:0] epoch_now,
    output logic [31:0] edge_total,
    output logic        pending_now,
    output logic [31:0] edge_age_ms
);

    localparam int DIV_ST     = 2 * ppstd_pkg::DIV_STEPS;
    localparam int NUM_STAGES = DIV_ST + 3;
    localparam int ST_SCALE   = NUM_STAGES - 2;
    localparam int ST_OUT     = NUM_STAGES - 1;
    localparam int CW         = ppstd_pkg::CHUNK_W;
    localparam int RW         = ppstd_pkg::REST_W;
    localparam int QW         = ppstd_pkg::QUO_W;

    // ---------------- pipe control ----------------
    logic [NUM_STAGES-1:0] vld_reg, vld_next, rdy;

    // ready ripples back from the output register
    always_comb
    begin
        rdy[ST_OUT] = !vld_reg[ST_OUT] || !res_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    always_comb
    begin
        vld_next[0] = rdy[0] ? cmd_valid : vld_reg[0];
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            vld_next[k] = rdy[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign cmd_stall = !rdy[0];
    assign res_valid = vld_reg[ST_OUT];

    // ---------------- config register ----------------
    logic [31:0] timeout_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            timeout_reg <= ppstd_pkg::TIMEOUT_RESET;
        else if (cfg_wr_en)
            timeout_reg <= cfg_wr_data;
    end

    // ---------------- stage 0: input register ----------------
    logic [2:0]  cmd_reg;
    logic [63:0] t_reg;
    logic [31:0] gepoch_reg;
    logic        gfix_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            cmd_reg    <= cmd;
            t_reg      <= time_us;
            gepoch_reg <= gps_epoch_s;
            gfix_reg   <= gps_fix;
        end
    end

    // ---------------- stage 0: state update ----------------
    logic [63:0] last_edge_reg, last_edge_next;
    logic [31:0] edge_count_reg, edge_count_next;
    logic        pending_reg, pending_next;
    logic        time_ok_reg, time_ok_next;
    logic        fix_reg, fix_next;

    logic [63:0]         diff, dividend;
    logic                ge, has_edge, timeout_hit, adv0;
    ppstd_pkg::ctl_t     ctl0;
    ppstd_pkg::div_t     seed;

    assign adv0 = vld_reg[0] && rdy[1];

    always_comb
    begin
        diff        = t_reg - last_edge_reg;
        ge          = t_reg >= last_edge_reg;
        has_edge    = |last_edge_reg;
        timeout_hit = (|diff[63:32]) || (diff[31:0] > timeout_reg);

        last_edge_next  = last_edge_reg;
        edge_count_next = edge_count_reg;
        pending_next    = pending_reg;
        time_ok_next    = time_ok_reg;
        fix_next        = fix_reg;
        dividend        = '0;

        ctl0           = '0;
        ctl0.has_edge  = has_edge;
        ctl0.ge        = ge;
        ctl0.gepoch    = gepoch_reg;

        case (ppstd_pkg::cmd_t'(cmd_reg))
            ppstd_pkg::CMD_EDGE:
            begin
                last_edge_next  = t_reg;
                edge_count_next = edge_count_reg + 32'd1;
                pending_next    = 1'b1;
            end
            ppstd_pkg::CMD_GPS:
            begin
                fix_next     = gfix_reg;
                time_ok_next = 1'b1;
                ctl0.ep_load = 1'b1;
            end
            ppstd_pkg::CMD_STAMP:
            begin
                ctl0.is_stamp = 1'b1;
                ctl0.ok       = has_edge && time_ok_reg;
                dividend      = ge ? diff : 64'd0;
            end
            ppstd_pkg::CMD_HEALTH:
            begin
                ctl0.is_health = 1'b1;
                dividend       = diff;
                if (has_edge && timeout_hit)
                begin
                    time_ok_next = 1'b0;
                    ctl0.ep_add  = time_ok_reg;
                end
            end
            ppstd_pkg::CMD_TAKE:
            begin
                ctl0.ok      = pending_reg && time_ok_reg;
                pending_next = 1'b0;
            end
            default:
            begin
            end
        endcase

        // status as it stands after this item
        ctl0.valid   = time_ok_next;
        ctl0.fix     = fix_next;
        ctl0.pending = pending_next;
        ctl0.count   = edge_count_next;

        seed      = '0;
        seed.n    = 32'(dividend[63:RW]);
        seed.rest = dividend[RW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_edge_reg  <= '0;
            edge_count_reg <= '0;
            pending_reg    <= 1'b0;
            time_ok_reg    <= 1'b0;
            fix_reg        <= 1'b0;
        end
        else if (adv0)
        begin
            last_edge_reg  <= last_edge_next;
            edge_count_reg <= edge_count_next;
            pending_reg    <= pending_next;
            time_ok_reg    <= time_ok_next;
            fix_reg        <= fix_next;
        end
    end

    // ---------------- control carried down the pipe ----------------
    ppstd_pkg::ctl_t ctl_reg [1:ST_SCALE];

    always_ff @(posedge clk)
    begin
        if (rdy[1])
            ctl_reg[1] <= ctl0;
        for (int k = 2; k <= ST_SCALE; k++)
        begin
            if (rdy[k])
                ctl_reg[k] <= ctl_reg[k-1];
        end
    end

    // ---------------- divide by one million ----------------
    ppstd_pkg::div_t div_reg  [1:DIV_ST];
    ppstd_pkg::div_t div_feed [0:DIV_ST];
    ppstd_pkg::div_t div_calc [1:DIV_ST];

    assign div_feed[0] = seed;

    genvar g;
    generate
        for (g = 1; g <= DIV_ST; g++)
        begin : g_feed
            assign div_feed[g] = div_reg[g];
        end

        for (g = 0; g < ppstd_pkg::DIV_STEPS; g++)
        begin : g_step
            logic [62:0] prod;
            logic [32:0] qd;
            logic [31:0] r32;

            // multiply by the reciprocal, keep the chunk quotient
            always_comb
            begin
                prod             = 63'(div_feed[2*g].n) * 63'(ppstd_pkg::SEC_MAGIC);
                div_calc[2*g+1]    = div_feed[2*g];
                div_calc[2*g+1].qm = prod[62:ppstd_pkg::SEC_SHIFT];
            end

            // remainder, then bring down the next chunk
            always_comb
            begin
                qd  = 33'(div_feed[2*g+1].qm) * 33'(ppstd_pkg::US_PER_S);
                r32 = div_feed[2*g+1].n - qd[31:0];
                div_calc[2*g+2]      = div_feed[2*g+1];
                div_calc[2*g+2].rem  = r32[19:0];
                div_calc[2*g+2].n    = {r32[19:0], div_feed[2*g+1].rest[RW-1:RW-CW]};
                div_calc[2*g+2].rest = {div_feed[2*g+1].rest[RW-CW-1:0], CW'(0)};
                div_calc[2*g+2].quo  = {div_feed[2*g+1].quo[QW-CW-1:0],
                                        div_feed[2*g+1].qm[CW-1:0]};
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        for (int k = 1; k <= DIV_ST; k++)
        begin
            if (rdy[k])
                div_reg[k] <= div_calc[k];
        end
    end

    // ---------------- scale stage: whole seconds and remainder to ms ----------------
    logic        sat_big_reg;
    logic [32:0] ms_whole_reg;
    logic [9:0]  ms_frac_reg;
    logic [31:0] quo_lo_reg;
    logic [19:0] rem_reg;
    logic [40:0] ms_prod;

    assign ms_prod = 41'(div_reg[DIV_ST].rem) * 41'(ppstd_pkg::MS_MAGIC);

    always_ff @(posedge clk)
    begin
        if (rdy[ST_SCALE])
        begin
            sat_big_reg  <= div_reg[DIV_ST].quo > ppstd_pkg::AGE_SEC_MAX;
            ms_whole_reg <= 33'(div_reg[DIV_ST].quo[22:0]) * 33'(ppstd_pkg::US_PER_MS);
            ms_frac_reg  <= ms_prod[ppstd_pkg::MS_SHIFT+9:ppstd_pkg::MS_SHIFT];
            quo_lo_reg   <= div_reg[DIV_ST].quo[31:0];
            rem_reg      <= div_reg[DIV_ST].rem;
        end
    end

    // ---------------- output stage: epoch update and result ----------------
    ppstd_pkg::ctl_t ctl_s;
    logic [31:0]     epoch_reg, epoch_next, epoch_sum;
    logic [32:0]     ms_sum;
    logic [31:0]     age_val;
    logic            adv_scale;

    logic [31:0] stamp_sec_reg, epoch_now_reg, edge_total_reg, edge_age_ms_reg;
    logic [19:0] stamp_frac_us_reg;
    logic        result_ok_reg, valid_now_reg, fix_now_reg, pending_now_reg;

    assign ctl_s     = ctl_reg[ST_SCALE];
    assign adv_scale = vld_reg[ST_SCALE] && rdy[ST_OUT];

    always_comb
    begin
        epoch_sum = epoch_reg + quo_lo_reg;
        if (ctl_s.ep_load)
            epoch_next = ctl_s.gepoch;
        else if (ctl_s.ep_add)
            epoch_next = epoch_sum;
        else
            epoch_next = epoch_reg;

        ms_sum = ms_whole_reg + 33'(ms_frac_reg);
        if (!ctl_s.has_edge || !ctl_s.ge || sat_big_reg || ms_sum[32])
            age_val = '1;
        else
            age_val = ms_sum[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            epoch_reg <= '0;
        else if (adv_scale)
            epoch_reg <= epoch_next;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[ST_OUT])
        begin
            stamp_sec_reg     <= (ctl_s.is_stamp && ctl_s.has_edge) ? epoch_sum : 32'd0;
            stamp_frac_us_reg <= (ctl_s.is_stamp && ctl_s.has_edge) ? rem_reg : 20'd0;
            result_ok_reg     <= ctl_s.ok;
            valid_now_reg     <= ctl_s.valid;
            fix_now_reg       <= ctl_s.fix;
            epoch_now_reg     <= epoch_next;
            edge_total_reg    <= ctl_s.count;
            pending_now_reg   <= ctl_s.pending;
            edge_age_ms_reg   <= ctl_s.is_health ? age_val : 32'd0;
        end
    end

    assign stamp_sec     = stamp_sec_reg;
    assign stamp_frac_us = stamp_frac_us_reg;
    assign result_ok     = result_ok_reg;
    assign valid_now     = valid_now_reg;
    assign fix_now       = fix_now_reg;
    assign epoch_now     = epoch_now_reg;
    assign edge_total    = edge_total_reg;
    assign pending_now   = pending_now_reg;
    assign edge_age_ms   = edge_age_ms_reg;

    // ---------------- assertions ----------------
    // input only stalls with every stage occupied
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> (&vld_reg))
        else $error("input stalled with a free stage");

    // remainder of the seconds divide stays below one second
    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (stamp_frac_us < ppstd_pkg::US_PER_S))
        else $error("stamp fraction out of range");

    // a good result needs valid time
    a_ok_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && result_ok) |-> valid_now)
        else $error("result_ok without valid time");

    // epoch only moves when a beat leaves the scale stage
    a_epoch_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv_scale |=> $stable(epoch_reg))
        else $error("epoch changed without a beat");

    // edge count only moves on an edge command
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(adv0 && (cmd_reg == ppstd_pkg::CMD_EDGE)) |=> $stable(edge_count_reg))
        else $error("edge count changed without an edge");

endmodule

/* dv/testbench.sv */
// Self-checking testbench for pps_time_discipline with a scoreboard that predicts each result.
`timescale 1ns / 100ps

module testbench;

    // One result beat, field by field
    typedef struct packed {
        logic [31:0] sec;
        logic [19:0] frac;
        logic        ok;
        logic        valid;
        logic        fix;
        logic [31:0] epoch;
        logic [31:0] count;
        logic        pending;
        logic [31:0] age;
    } pps_status_t;

    // Shadow of the time base: predicts the status of every accepted command
    class pps_shadow;
        logic [63:0] edge_us;
        logic [31:0] epoch;
        logic [31:0] edges;
        logic        pending;
        logic        valid;
        logic        fix;
        logic [31:0] timeout_us;
        pps_status_t awaited_status[$];
        int          errors;

        function new();
            edge_us    = '0;
            epoch      = '0;
            edges      = '0;
            pending    = 1'b0;
            valid      = 1'b0;
            fix        = 1'b0;
            timeout_us = ppstd_pkg::TIMEOUT_RESET;
            errors     = 0;
        endfunction

        function void set_timeout(logic [31:0] value);
            timeout_us = value;
        endfunction

        function int outstanding();
            return awaited_status.size();
        endfunction

        // Apply one command to the shadow state and queue its status
        function void note_command(ppstd_pkg::cmd_t c, logic [63:0] t,
                                   logic [31:0] g_epoch, logic g_fix);
            pps_status_t s;
            logic [63:0] offset;
            logic [63:0] elapsed;
            logic [63:0] ms;
            s = '0;
            case (c)
                ppstd_pkg::CMD_EDGE:
                begin
                    edge_us = t;
                    edges   = edges + 32'd1;
                    pending = 1'b1;
                end
                ppstd_pkg::CMD_GPS:
                begin
                    epoch = g_epoch;
                    fix   = g_fix;
                    valid = 1'b1;
                end
                ppstd_pkg::CMD_STAMP:
                begin
                    // zero edge time reads as no edge; early events clamp to the edge
                    if (edge_us != '0)
                    begin
                        offset  = (t >= edge_us) ? t - edge_us : 64'd0;
                        s.sec   = epoch + 32'(offset / 64'd1000000);
                        s.frac  = 20'(offset % 64'd1000000);
                        s.ok    = valid;
                    end
                end
                ppstd_pkg::CMD_HEALTH:
                begin
                    if (edge_us != '0)
                    begin
                        // elapsed wraps when the current time is before the edge
                        elapsed = t - edge_us;
                        if (elapsed > {32'd0, timeout_us})
                        begin
                            if (valid)
                                epoch = epoch + 32'(elapsed / 64'd1000000);
                            valid = 1'b0;
                        end
                        if (t < edge_us)
                            s.age = '1;
                        else
                        begin
                            ms    = elapsed / 64'd1000;
                            s.age = (ms > 64'hFFFF_FFFF) ? '1 : ms[31:0];
                        end
                    end
                    else
                        s.age = '1;
                end
                ppstd_pkg::CMD_TAKE:
                begin
                    s.ok    = pending && valid;
                    pending = 1'b0;
                end
                default: ;
            endcase
            s.valid   = valid;
            s.fix     = fix;
            s.epoch   = epoch;
            s.count   = edges;
            s.pending = pending;
            awaited_status.push_back(s);
        endfunction

        function void check_field(string field, logic [63:0] want, logic [63:0] seen);
            if (want !== seen)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", field, want, seen);
                errors++;
            end
        endfunction

        // Compare one result beat with the oldest prediction
        function void check_result(pps_status_t got);
            pps_status_t want;
            if (awaited_status.size() == 0)
            begin
                $error("result beat with no command outstanding");
                errors++;
                return;
            end
            want = awaited_status.pop_front();
            check_field("stamp_sec", 64'(want.sec), 64'(got.sec));
            check_field("stamp_frac_us", 64'(want.frac), 64'(got.frac));
            check_field("result_ok", 64'(want.ok), 64'(got.ok));
            check_field("valid_now", 64'(want.valid), 64'(got.valid));
            check_field("fix_now", 64'(want.fix), 64'(got.fix));
            check_field("epoch_now", 64'(want.epoch), 64'(got.epoch));
            check_field("edge_total", 64'(want.count), 64'(got.count));
            check_field("pending_now", 64'(want.pending), 64'(got.pending));
            check_field("edge_age_ms", 64'(want.age), 64'(got.age));
        endfunction
    endclass

    localparam int IDLE_LIMIT   = 5000;
    localparam int PHASE_ITEMS  = 132;
    localparam int DRAIN_CYCLES = 12;

    logic            clk         = 1'b0;
    logic            rst_n       = 1'b0;
    logic            cfg_wr_en   = 1'b0;
    logic [31:0]     cfg_wr_data = '0;
    logic            cmd_valid   = 1'b0;
    logic            cmd_stall;
    ppstd_pkg::cmd_t cmd         = ppstd_pkg::CMD_EDGE;
    logic [63:0]     time_us     = '0;
    logic [31:0]     gps_epoch_s = '0;
    logic            gps_fix     = 1'b0;
    logic            res_valid;
    logic            res_stall   = 1'b0;
    logic [31:0]     stamp_sec;
    logic [19:0]     stamp_frac_us;
    logic            result_ok;
    logic            valid_now;
    logic            fix_now;
    logic [31:0]     epoch_now;
    logic [31:0]     edge_total;
    logic            pending_now;
    logic [31:0]     edge_age_ms;

    pps_shadow   shadow = new();
    pps_status_t seen_status;
    int          send_gap_pct = 0;
    int          stall_pct    = 0;
    int          idle_cycles  = 0;
    logic [63:0] now_us       = '0;
    logic [63:0] edge_mark    = '0;

    always #5 clk = ~clk;

    pps_time_discipline i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .cmd_valid     (cmd_valid),
        .cmd_stall     (cmd_stall),
        .cmd           (cmd),
        .time_us       (time_us),
        .gps_epoch_s   (gps_epoch_s),
        .gps_fix       (gps_fix),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .stamp_sec     (stamp_sec),
        .stamp_frac_us (stamp_frac_us),
        .result_ok     (result_ok),
        .valid_now     (valid_now),
        .fix_now       (fix_now),
        .epoch_now     (epoch_now),
        .edge_total    (edge_total),
        .pending_now   (pending_now),
        .edge_age_ms   (edge_age_ms)
    );

    always_comb
        seen_status = '{sec: stamp_sec, frac: stamp_frac_us, ok: result_ok,
                        valid: valid_now, fix: fix_now, epoch: epoch_now,
                        count: edge_total, pending: pending_now, age: edge_age_ms};

    // Result side: check accepted beats, then pick the next stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
                shadow.check_result(seen_status);
            res_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Present one command beat, with optional idle cycles ahead of it
    task automatic send_cmd(ppstd_pkg::cmd_t c, logic [63:0] t,
                            logic [31:0] g_epoch, logic g_fix);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid   <= 1'b1;
        cmd         <= c;
        time_us     <= t;
        gps_epoch_s <= g_epoch;
        gps_fix     <= g_fix;
        do
            @(posedge clk);
        while (cmd_stall);
        shadow.note_command(c, t, g_epoch, g_fix);
    endtask

    // Let every outstanding result come back, then write the timeout
    task automatic set_timeout(logic [31:0] value);
        cmd_valid <= 1'b0;
        while (shadow.outstanding() != 0)
            @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        shadow.set_timeout(value);
    endtask

    // Mostly a plausible PPS timeline, some outages, some raw noise
    task automatic run_random(int count);
        ppstd_pkg::cmd_t c;
        logic [63:0]     t;
        int              pick;
        repeat (count)
        begin
            pick   = $urandom_range(0, 99);
            now_us = now_us + 64'($urandom_range(0, 400000));
            if ($urandom_range(0, 39) == 0)
                now_us = now_us + 64'($urandom_range(1000000, 6000000));
            if ($urandom_range(0, 149) == 0)
                now_us = {$urandom, $urandom};
            t = now_us;
            if (pick < 20)
            begin
                c         = ppstd_pkg::CMD_EDGE;
                edge_mark = t;
            end
            else if (pick < 30)
                c = ppstd_pkg::CMD_GPS;
            else if (pick < 55)
            begin
                c = ppstd_pkg::CMD_STAMP;
                if ($urandom_range(0, 9) == 0)
                    t = edge_mark - 64'($urandom_range(1, 5000));
            end
            else if (pick < 80)
                c = ppstd_pkg::CMD_HEALTH;
            else if (pick < 92)
                c = ppstd_pkg::CMD_TAKE;
            else
            begin
                // raw noise, unused command codes included
                c = ppstd_pkg::cmd_t'(3'($urandom_range(0, 7)));
                t = {$urandom, $urandom};
                if (pick >= 98)
                    t = 64'($urandom_range(0, 3));
                else if (pick >= 96)
                    t = ~64'($urandom_range(0, 3));
            end
            send_cmd(c, t, $urandom, 1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset timeout, corner times and every command
        send_cmd(ppstd_pkg::CMD_HEALTH, 64'd5, 32'd0, 1'b0);
        send_cmd(ppstd_pkg::CMD_STAMP, 64'd12345, 32'd0, 1'b0);
        send_cmd(ppstd_pkg::CMD_TAKE, 64'd0, 32'd0, 1'b0);
        send_cmd(ppstd_pkg::CMD_GPS, 64'd0, 32'hFFFF_FFFF, 1'b1);
        send_cmd(ppstd_pkg::CMD_EDGE, 64'd0, 32'd0, 1'b0);
        send_cmd(ppstd_pkg::CMD_STAMP, 64'd12345, 32'd0, 1'b0);
        send_cmd(ppstd_pkg::CMD_HEALTH, 64'd3000000, 32'd0, 1'b0);
        send_cmd(ppstd_pkg::CMD_TAKE, 64'd0, 32'd0, 1'b0);
        send_cmd(ppstd_pkg::CMD_EDGE, 64'd1000000, 32'd0, 1'b0);
        send_cmd(ppstd_pkg::CMD_STAMP, 64'd3500000, 32'd0, 1'b0);
        send_cmd(ppstd_pkg::CMD_STAMP, 64'd500, 32'd0, 1'b0);
        send_cmd(ppstd_pkg::CMD_HEALTH, 64'd3000000, 32'd0, 1'b0);
        send_cmd(ppstd_pkg::CMD_HEALTH, 64'd3000001, 32'd0, 1'b0);
        send_cmd(ppstd_pkg::CMD_STAMP, 64'd3000001, 32'd0, 1'b0);
        send_cmd(ppstd_pkg::CMD_EDGE, '1, 32'd0, 1'b0);
        send_cmd(ppstd_pkg::CMD_HEALTH, 64'd0, 32'd0, 1'b0);
        send_cmd(ppstd_pkg::CMD_GPS, 64'd0, 32'd0, 1'b0);
        send_cmd(ppstd_pkg::CMD_EDGE, 64'h8000_0000_0000_0000, 32'd0, 1'b0);
        send_cmd(ppstd_pkg::CMD_HEALTH, 64'd5, 32'd0, 1'b0);
        send_cmd(ppstd_pkg::CMD_GPS, 64'd0, 32'h1234_5678, 1'b1);
        send_cmd(ppstd_pkg::CMD_EDGE, 64'd1000, 32'd0, 1'b0);
        send_cmd(ppstd_pkg::CMD_HEALTH, 64'd1000 + 64'd4294967295999, 32'd0, 1'b0);
        send_cmd(ppstd_pkg::CMD_EDGE, 64'd1, 32'd0, 1'b0);
        send_cmd(ppstd_pkg::CMD_HEALTH, '1, 32'd0, 1'b0);
        send_cmd(ppstd_pkg::CMD_TAKE, 64'd0, 32'd0, 1'b0);

        // Random phases, each with its own timeout and idling
        run_random(PHASE_ITEMS);

        set_timeout(32'd1);
        send_gap_pct = 56;
        stall_pct    = 0;
        run_random(PHASE_ITEMS);

        set_timeout(32'hFFFF_FFFF);
        send_gap_pct = 0;
        stall_pct    = 56;
        run_random(PHASE_ITEMS);

        set_timeout(32'($urandom_range(1000, 5000000)));
        send_gap_pct = 11;
        stall_pct    = 11;
        run_random(PHASE_ITEMS);

        // Drain, then allow for any stray beat
        cmd_valid <= 1'b0;
        while (shadow.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (shadow.errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
